### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the emoji stripper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### src/emjs_pkg.sv
// ----------------------------------------------------------------------------
// emjs_pkg
// Types and constants shared by the emoji stripper front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package emjs_pkg;

  localparam int unsigned SEQ_MAX = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CODE_W  = 31;

  localparam logic [CODE_W-1:0] EMOJI_LOW  = 31'h0001_F300;
  localparam logic [CODE_W-1:0] EMOJI_HIGH = 31'h0001_F6FF;
  localparam logic [CNT_W-1:0]  MAX_CODED_LEN = 4'd6;

  // one request for the back end: a run of kept bytes, or a bare end marker
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

`default_nettype wire

### src/emjs_front.sv
// ----------------------------------------------------------------------------
// emjs_front
// Accepts bytes, tracks the open UTF-8 sequence, decodes the code point and
// issues a run request for every step that yields output or ends a string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module emjs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              string_last,
  input  logic              q_full,
  output emjs_pkg::push_t   push
);
  import emjs_pkg::*;

  logic [CNT_W-1:0]  seq_len;
  logic [CNT_W-1:0]  held;
  logic [CODE_W-1:0] code;
  logic [7:0]        seq_buf [SEQ_MAX];

  logic [CNT_W-1:0]  lead_len;
  logic [CNT_W-1:0]  len_next;
  logic [CNT_W-1:0]  held_next;
  logic [CODE_W-1:0] code_next;
  logic [IDX_W-1:0]  wr_idx;
  logic              open_seq;
  logic              accept;
  logic              complete;
  logic              emoji;
  logic [CNT_W-1:0]  emit_cnt;
  logic [7:0]        lead_mask;

  assign open_seq = seq_len != '0;
  assign in_stall = q_full;
  assign accept   = in_valid & ~in_stall;
  assign wr_idx   = open_seq ? held[IDX_W-1:0] : '0;

  always_comb begin
    casez (in_byte)
      8'b10??????: lead_len = 4'd1;
      8'b110?????: lead_len = 4'd2;
      8'b1110????: lead_len = 4'd3;
      8'b11110???: lead_len = 4'd4;
      8'b111110??: lead_len = 4'd5;
      8'b1111110?: lead_len = 4'd6;
      8'b11111110: lead_len = 4'd7;
      8'b11111111: lead_len = 4'd8;
      default:     lead_len = 4'd0;
    endcase
  end

  assign lead_mask = 8'h7F >> lead_len;

  always_comb begin
    if (!open_seq) begin
      len_next  = lead_len;
      held_next = 4'd1;
      code_next = (lead_len <= MAX_CODED_LEN) ? CODE_W'(in_byte & lead_mask) : '0;
    end else begin
      len_next  = seq_len;
      held_next = held + 4'd1;
      code_next = (seq_len <= MAX_CODED_LEN) ? {code[CODE_W-7:0], in_byte[5:0]} : code;
    end
  end

  assign complete = (len_next == '0) || (held_next >= len_next);
  assign emoji    = (len_next != '0) && (len_next <= MAX_CODED_LEN) &&
                    (code_next >= EMOJI_LOW) && (code_next <= EMOJI_HIGH);

  always_comb begin
    if (complete) begin
      emit_cnt = emoji ? '0 : held_next;
    end else if (string_last) begin
      emit_cnt = held_next;
    end else begin
      emit_cnt = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < SEQ_MAX; i++) begin
      push.cmd.bytes[i] = seq_buf[i];
    end
    push.cmd.bytes[wr_idx] = in_byte;
    push.cmd.count = emit_cnt;
    push.cmd.last  = string_last;
    push.valid     = accept & ((emit_cnt != '0) | string_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= '0;
      held    <= '0;
      code    <= '0;
    end else if (accept) begin
      if (complete || string_last) begin
        seq_len <= '0;
        held    <= '0;
        code    <= '0;
      end else begin
        seq_len <= len_next;
        held    <= held_next;
        code    <= code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_buf[wr_idx] <= in_byte;
    end
  end

  `ASSERT_PROP(a_held_le_len, clk, rst, held <= seq_len)
  `ASSERT_PROP(a_idle_empty, clk, rst, (seq_len == '0) |-> (held == '0))
  `ASSERT_NEVER(a_no_len_one_open, clk, rst, seq_len == 4'd1)
  `ASSERT_PROP(a_last_pushes, clk, rst, (accept && string_last) |-> push.valid)

endmodule

`default_nettype wire

### src/emjs_queue.sv
// ----------------------------------------------------------------------------
// emjs_queue
// Small FIFO of run requests between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module emjs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  emjs_pkg::push_t  push,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output emjs_pkg::cmd_t   head
);
  import emjs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          do_push;
  logic          do_pop;

  assign full    = fill == CW'(DEPTH);
  assign empty   = fill == '0;
  assign do_push = push.valid & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push.valid && full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty)
  `ASSERT_PROP(a_fill_bound, clk, rst, fill <= CW'(DEPTH))

endmodule

`default_nettype wire

### src/emjs_back.sv
// ----------------------------------------------------------------------------
// emjs_back
// Drains queued run requests, one output byte per cycle unless out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module emjs_back (
  input  logic             clk,
  input  logic             rst,
  input  emjs_pkg::cmd_t   head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_present,
  output logic             run_last,
  output logic             string_end
);
  import emjs_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             marker;
  logic             final_byte;
  logic             fire;

  assign marker     = head.count == '0;
  assign final_byte = marker || ({1'b0, idx} == (head.count - 4'd1));
  assign out_valid  = ~empty;
  assign fire       = out_valid & ~out_stall;
  assign pop        = fire & final_byte;

  assign out_byte     = marker ? 8'h00 : head.bytes[idx];
  assign byte_present = ~marker;
  assign run_last     = final_byte;
  assign string_end   = final_byte & head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= final_byte ? '0 : idx + 1'b1;
    end
  end

endmodule

`default_nettype wire

### src/utf8_emoji_stripper_unit.sv
// ----------------------------------------------------------------------------
// utf8_emoji_stripper_unit
// Removes UTF-8 sequences whose code point is in U+1F300..U+1F6FF from a
// byte stream; all other bytes pass in order.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | in_byte, string_last
//   out     | out_valid/out_stall| out_byte, byte_present, run_last, string_end
//
// One input byte per cycle is taken while the run queue has a free slot.
// A run of kept bytes is written to the run queue when the byte that closes it
// is taken and leaves one byte per cycle while out_stall is low; the back-end
// drain port sets this pace. The queue holds QUEUE_DEPTH runs, so output stalls
// back up into in_stall. Synchronous reset closes any open sequence and empties
// the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_emoji_stripper_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       string_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       run_last,
  output logic       string_end
);
  import emjs_pkg::*;

  push_t push;
  cmd_t  head;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  emjs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .string_last (string_last),
    .q_full      (q_full),
    .push        (push)
  );

  emjs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (head)
  );

  emjs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .run_last     (run_last),
    .string_end   (string_end)
  );

endmodule

`default_nettype wire

### tb/utf8_emoji_stripper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_emoji_stripper_unit_tb
// Drives byte requests through the emoji stripper and checks every output
// byte against a cycle-free predictor of the sequence decode and drop rule.
// Directed strings hit the boundaries and odd leads, then random text mixes
// well-formed sequences near the emoji range with broken and cut-off ones.
// ----------------------------------------------------------------------------
module utf8_emoji_stripper_unit_tb;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold_first;
  } text_req_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       run_end;
    logic       str_end;
  } kept_byte_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       string_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       string_end;

  text_req_t  text_q[$];
  kept_byte_t kept_q[$];
  int         n_errors = 0;
  int         n_taken = 0;
  bit         pause_next = 0;

  // predictor state
  logic [7:0]  seq_buf [8];
  logic [3:0]  seq_len = '0;
  logic [3:0]  held = '0;
  logic [30:0] code = '0;

  utf8_emoji_stripper_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .string_last  (string_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .run_last     (run_last),
    .string_end   (string_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic strip_step(input logic [7:0] b, input logic last);
    kept_byte_t run[$];
    kept_byte_t rec;
    logic [3:0] len;
    logic [7:0] m;
    logic       hit;
    if (seq_len == 0) begin
      if (!b[7]) begin
        run = {run, kept_byte_t'{b, 1'b1, 1'b0, 1'b0}};
      end else begin
        len = 4'd1;
        m = 8'h40;
        while (m != 0 && (b & m) != 0) begin
          len++;
          m >>= 1;
        end
        seq_len = len;
        seq_buf[0] = b;
        held = 4'd1;
        code = '0;
        if (len <= 6) code[7:0] = b & (8'h7F >> len);
      end
    end else begin
      seq_buf[held[2:0]] = b;
      held++;
      if (seq_len <= 6) code = {code[24:0], b[5:0]};
    end
    if (seq_len != 0 && held >= seq_len) begin
      hit = seq_len <= 6 && code >= emjs_pkg::EMOJI_LOW && code <= emjs_pkg::EMOJI_HIGH;
      if (!hit) begin
        for (int i = 0; i < held; i++) begin
          run = {run, kept_byte_t'{seq_buf[i], 1'b1, 1'b0, 1'b0}};
        end
      end
      seq_len = '0;
      held = '0;
      code = '0;
    end
    if (last) begin
      // cut-off sequence goes out as is
      if (seq_len != 0) begin
        for (int i = 0; i < held; i++) begin
          run = {run, kept_byte_t'{seq_buf[i], 1'b1, 1'b0, 1'b0}};
        end
        seq_len = '0;
        held = '0;
        code = '0;
      end
      if (run.size() == 0) run = {run, kept_byte_t'{8'h00, 1'b0, 1'b0, 1'b0}};
    end
    for (int i = 0; i < run.size(); i++) begin
      rec = run[i];
      if (i == run.size() - 1) begin
        rec.run_end = 1'b1;
        rec.str_end = last;
      end
      kept_q = {kept_q, rec};
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    text_q = {text_q, text_req_t'{b, last, pause_next}};
    pause_next = 0;
  endtask

  // n-byte sequence carrying cp; noisy scrambles the continuation marks
  task automatic add_seq(input int n, input logic [47:0] cp, input bit noisy,
                         input int cut_at);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = (8'hFF << (8 - n)) | 8'(cp >> (6 * (n - 1)));
      end else begin
        b = 8'h80 | 8'((cp >> (6 * (n - 1 - i))) & 48'h3F);
        if (noisy) b[7:6] = 2'($urandom);
      end
      add_byte(b, i == cut_at);
    end
  endtask

  // sender
  text_req_t cur;
  bit        busy;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        strip_step(in_byte, string_last);
        n_taken++;
        busy = 0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (text_q[0].hold_first && kept_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          cur = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= cur.data;
          string_last <= cur.last;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int  hold_left = 0;
  bit  hold_done = 0;
  int  phase_left = 0;
  int  stall_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_taken >= 60) begin
      hold_done = 1;
      hold_left = 80;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(5, 40);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // output check
  kept_byte_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (kept_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected output byte %h present %b", $time, out_byte, byte_present);
      end else begin
        want = kept_q.pop_front();
        if (out_byte !== want.data) begin
          n_errors++;
          $display("%0t: out_byte exp %h got %h", $time, want.data, out_byte);
        end
        if (byte_present !== want.present) begin
          n_errors++;
          $display("%0t: byte_present exp %b got %b", $time, want.present, byte_present);
        end
        if (run_last !== want.run_end) begin
          n_errors++;
          $display("%0t: run_last exp %b got %b", $time, want.run_end, run_last);
        end
        if (string_end !== want.str_end) begin
          n_errors++;
          $display("%0t: string_end exp %b got %b", $time, want.str_end, string_end);
        end
      end
    end
  end

  initial begin
    int n;
    int cut;
    int start;
    int r;
    // plain ASCII, lone continuation, two-byte char
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_seq(2, 48'hE9, 0, -1);
    // both ends of the emoji range; the second closes its string with nothing kept
    add_seq(4, 48'h1F300, 0, -1);
    add_seq(4, 48'h1F6FF, 0, 3);
    // eight-byte lead with junk followers
    add_seq(8, 48'({$urandom, $urandom}), 1, -1);
    // three-byte sequence cut off at string end
    add_seq(3, 48'h20AC, 0, 1);
    add_byte(8'h7F, 1'b1);

    start = text_q.size();
    pause_next = 1;
    while (text_q.size() - start < 75) begin
      if (text_q.size() - start >= 50 && text_q.size() - start < 55) pause_next = 1;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_byte(8'($urandom_range(0, 127)), $urandom_range(0, 9) == 0);
      end else if (r < 88 && r >= 80) begin
        add_byte(8'h80 | 8'($urandom_range(0, 63)), $urandom_range(0, 9) == 0);
      end else begin
        if (r < 55) n = 4;
        else if (r < 65) n = $urandom_range(5, 6);
        else if (r < 80) n = $urandom_range(2, 3);
        else n = $urandom_range(5, 8);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
        if (r < 65)
          add_seq(n, 48'($urandom_range(32'h1F2E0, 32'h1F720)), $urandom_range(0, 4) == 0, cut);
        else if (r < 80)
          add_seq(n, 48'($urandom_range(0, (n == 2) ? 32'h7FF : 32'hFFFF)), 0, cut);
        else
          add_seq(n, 48'({$urandom, $urandom}), 1, cut);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (text_q.size() != 0 || in_valid || kept_q.size() != 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
